// ----- rtl/core/hsfc_pkg.sv -----
// Shared types and constants for the half/single float converter.
// No dependencies; imported by every pipeline stage and the top level.
package hsfc_pkg;

   localparam logic [31:0] SGL_QNAN      = 32'h7FC0_0000;
   localparam logic [31:0] SGL_INF       = 32'h7F80_0000;
   localparam logic [14:0] HALF_INF      = 15'h7C00;
   localparam logic [4:0]  HALF_EXP_MAX  = 5'h1F;
   localparam logic [7:0]  SGL_EXP_MAX   = 8'hFF;
   localparam logic [7:0]  BIAS_DIFF     = 8'd112;
   localparam logic [7:0]  SUB_EXP_BASE  = 8'd103;
   localparam logic [7:0]  S2H_OVF_EXP   = 8'd143;
   localparam logic [7:0]  S2H_NORM_EXP  = 8'd113;
   localparam logic [7:0]  S2H_SUB_EXP   = 8'd102;
   localparam logic [4:0]  SGL_FRAC_TOP  = 5'd23;

   typedef enum logic [3:0] {
      KIND_H_ZERO,
      KIND_H_SUB,
      KIND_H_NORM,
      KIND_H_INF,
      KIND_H_NAN,
      KIND_S_ZERO,
      KIND_S_SUB,
      KIND_S_NORM,
      KIND_S_INF,
      KIND_S_NAN
   } kind_type;

   // decode stage output
   typedef struct packed {
      kind_type    kind;
      logic        sign;
      logic [3:0]  amt;    // half leading-one index, or single denorm shift
      logic [4:0]  exp;    // half exponent, or rebiased single exponent
      logic [22:0] frac;
   } dec_type;

   // shift stage output
   typedef struct packed {
      kind_type    kind;
      logic        sign;
      logic [4:0]  exp;
      logic [31:0] word;   // final single, or mantissa before rounding
   } shf_type;

endpackage

// ----- rtl/core/hsfc_decode.sv -----
// Stage 1: classifies the operand and finds exponent, shift and leading one.
// Depends on hsfc_pkg.
module hsfc_decode
   import hsfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic        in_func,
   input  logic [31:0] in_operand,
   output logic        out_valid,
   input  logic        out_ready,
   output dec_type     out_data
);

   logic    valid_ff, valid_in;
   dec_type data_ff, data_in;

   logic [4:0] he;
   logic [9:0] hf;
   logic [7:0] se;
   logic [3:0] lead;
   logic [7:0] rebias;
   logic [7:0] dshift;

   assign he     = in_operand[14:10];
   assign hf     = in_operand[9:0];
   assign se     = in_operand[30:23];
   assign rebias = se - BIAS_DIFF;
   assign dshift = S2H_NORM_EXP - se;

   always_comb begin
      lead = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (hf[i]) begin
            lead = 4'(i);
         end
      end
   end

   always_comb begin
      data_in = data_ff;
      if (in_func == 1'b0) begin
         data_in.sign = in_operand[15];
         data_in.amt  = lead;
         data_in.exp  = he;
         data_in.frac = {13'd0, hf};
         if (he == HALF_EXP_MAX) begin
            data_in.kind = (hf != 10'd0) ? KIND_H_NAN : KIND_H_INF;
         end else if (he != 5'd0) begin
            data_in.kind = KIND_H_NORM;
         end else if (hf == 10'd0) begin
            data_in.kind = KIND_H_ZERO;
         end else begin
            data_in.kind = KIND_H_SUB;
         end
      end else begin
         data_in.sign = in_operand[31];
         data_in.amt  = dshift[3:0];
         data_in.exp  = rebias[4:0];
         data_in.frac = in_operand[22:0];
         if (se == SGL_EXP_MAX) begin
            data_in.kind = KIND_S_NAN;
         end else if (se >= S2H_OVF_EXP) begin
            data_in.kind = KIND_S_INF;
         end else if (se >= S2H_NORM_EXP) begin
            data_in.kind = KIND_S_NORM;
         end else if (se >= S2H_SUB_EXP) begin
            data_in.kind = KIND_S_SUB;
         end else begin
            data_in.kind = KIND_S_ZERO;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/core/hsfc_shift.sv -----
// Stage 2: builds single results and aligns single mantissas for rounding.
// Depends on hsfc_pkg.
module hsfc_shift
   import hsfc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  dec_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output shf_type out_data
);

   logic    valid_ff, valid_in;
   shf_type data_ff, data_in;

   logic [23:0] norm_sh;
   logic [23:0] denorm_sh;
   logic [7:0]  norm_exp;
   logic [7:0]  sub_exp;

   assign norm_sh   = 24'(in_data.frac[9:0]) << (SGL_FRAC_TOP - {1'b0, in_data.amt});
   assign denorm_sh = {1'b1, in_data.frac} >> in_data.amt;
   assign norm_exp  = {3'd0, in_data.exp} + BIAS_DIFF;
   assign sub_exp   = {4'd0, in_data.amt} + SUB_EXP_BASE;

   always_comb begin
      data_in.kind = in_data.kind;
      data_in.sign = in_data.sign;
      data_in.exp  = in_data.exp;
      case (in_data.kind)
         KIND_H_NAN:  data_in.word = SGL_QNAN | {in_data.sign, 31'd0};
         KIND_H_INF:  data_in.word = SGL_INF | {in_data.sign, 31'd0};
         KIND_H_ZERO: data_in.word = {in_data.sign, 31'd0};
         KIND_H_NORM: data_in.word = {in_data.sign, norm_exp, in_data.frac[9:0], 13'd0};
         KIND_H_SUB:  data_in.word = {in_data.sign, sub_exp, norm_sh[22:0]};
         KIND_S_SUB:  data_in.word = {8'd0, denorm_sh};
         default:     data_in.word = {9'd0, in_data.frac};
      endcase
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/core/hsfc_round.sv -----
// Stage 3: rounds half results half-up and drives the output register.
// Depends on hsfc_pkg.
module hsfc_round
   import hsfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  shf_type     in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] out_result
);

   logic        valid_ff, valid_in;
   logic [31:0] result_ff, result_in;

   logic [14:0] norm_val;
   logic [10:0] sub_val;

   // rounding carry ripples into the exponent
   assign norm_val = {in_data.exp, 10'd0} + 15'(in_data.word[22:13])
                   + 15'(in_data.word[12]);
   assign sub_val  = in_data.word[23:13] + 11'(in_data.word[12]);

   always_comb begin
      case (in_data.kind)
         KIND_S_ZERO: result_in = 32'd0;
         KIND_S_INF:  result_in = {16'd0, in_data.sign, HALF_INF};
         KIND_S_NAN:  result_in = {16'd0, in_data.sign, HALF_EXP_MAX, in_data.word[22:13]};
         KIND_S_NORM: result_in = {16'd0, in_data.sign, norm_val};
         KIND_S_SUB:  result_in = {16'd0, in_data.sign, 4'd0, sub_val};
         default:     result_in = in_data.word;
      endcase
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// ----- rtl/core/half_single_float_converter_unit.sv -----
// Half/single float converter, three register stages: decode, shift, round.
// Each operand is registered in the decode, shift and round stages in turn before rsp_tvalid.
// Throughput: one transfer per cycle while rsp_tready is high; each stage holds while the next is not ready.
// Reset (synchronous, active high) clears all stage valid bits.
// Depends on hsfc_pkg, hsfc_decode, hsfc_shift, hsfc_round.
module half_single_float_converter_unit
   import hsfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] operand
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] result
);

   logic    dec_valid, dec_ready;
   dec_type dec_data;
   logic    shf_valid, shf_ready;
   shf_type shf_data;

   hsfc_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_func    (req_tuser),
      .in_operand (req_tdata),
      .out_valid  (dec_valid),
      .out_ready  (dec_ready),
      .out_data   (dec_data)
   );

   hsfc_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (shf_valid),
      .out_ready (shf_ready),
      .out_data  (shf_data)
   );

   hsfc_round u_round (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (shf_valid),
      .in_ready   (shf_ready),
      .in_data    (shf_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_tdata)
   );

endmodule
